/* design/dgd_pkg.sv */
// shared types, constants and exponential tables for the gaussian density scorer
// no dependencies; used by dgd_accum, dgd_density and the top level
`default_nettype none

package dgd_pkg;

    // table depth and addressing
    localparam int MAX_DIM = 64;
    localparam int ADDR_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    typedef logic [ADDR_W-1:0] t_addr;

    // packed table word: mean in the upper half, inverse variance in the lower
    localparam int TBL_W = 32;

    // accumulator, unsigned Q32.8
    localparam int ACC_W = 40;
    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    // exp(-q/2): q has 9 fraction bits below the integer part of q/2
    localparam int FRAC_BITS  = 9;
    localparam int INT_LIMIT  = 32;
    localparam int INT_IDX_W  = $clog2(INT_LIMIT);
    localparam int EXP_DEPTH  = 256;
    localparam int EXP_IDX_W  = $clog2(EXP_DEPTH);
    localparam int EXP_PROD_W = FRAC_BITS + EXP_IDX_W + 1;
    typedef logic [EXP_IDX_W-1:0]  t_exp_idx;
    typedef logic [EXP_PROD_W-1:0] t_exp_prod;

    // Q0.32 with 1.0 held as 2^32, hence 33 bits
    localparam int ROM_W = 33;
    localparam logic [63:0] Q_ONE = 64'h0000_0001_0000_0000;
    typedef logic [ROM_W-1:0] t_rom_word;
    typedef t_rom_word t_frac_rom [EXP_DEPTH];
    typedef t_rom_word t_int_rom  [INT_LIMIT];

    // reset values
    localparam logic [31:0] PREF_RESET  = 32'd1713444146;
    localparam logic [15:0] INV_VAR_ONE = 16'd256;

    // item kinds
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_DATA = 1'b1;

    // configuration register indices
    typedef enum logic [1:0] {
        CFG_USE_WEIGHT = 2'd0,
        CFG_SUB_MEAN   = 2'd1,
        CFG_W_PREF     = 2'd2,
        CFG_U_PREF     = 2'd3
    } t_cfg_idx;

    // end-of-vector hand-off from the accumulator to the density unit
    typedef struct packed {
        logic             valid;
        logic [ACC_W-1:0] q;
        logic             sat;
    } t_vec_end;

    // truncating series through the a^14 term for exp(-a), a in Q0.32; elaboration only
    function automatic t_rom_word exp_series(input logic [63:0] a);
        logic [63:0] term;
        longint      sum;
        term = Q_ONE;
        sum  = longint'(Q_ONE);
        for (int n = 1; n <= 14; n++) begin
            term = ((term * a) >> 32) / 64'(n);
            if (n % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > longint'(Q_ONE)) begin
            sum = longint'(Q_ONE);
        end
        return t_rom_word'(sum);
    endfunction

    function automatic t_frac_rom build_frac_rom();
        t_frac_rom rom;
        for (int k = 0; k < EXP_DEPTH; k++) begin
            rom[k] = exp_series((64'(k) << 32) / EXP_DEPTH);
        end
        return rom;
    endfunction

    function automatic t_int_rom build_int_rom();
        t_int_rom    rom;
        logic [63:0] half;
        logic [63:0] e1;
        logic [63:0] acc;
        half   = 64'(exp_series(Q_ONE >> 1));
        e1     = (half * half) >> 32;
        acc    = Q_ONE;
        rom[0] = t_rom_word'(acc);
        for (int k = 1; k < INT_LIMIT; k++) begin
            acc    = (acc * e1) >> 32;
            rom[k] = t_rom_word'(acc);
        end
        return rom;
    endfunction

    localparam t_frac_rom FRAC_ROM = build_frac_rom();
    localparam t_int_rom  INT_ROM  = build_int_rom();

endpackage

`default_nettype wire

/* design/diag_gaussian_density.sv */
// Scores a vector, one signed Q8.8 element per beat, against a diagonal Gaussian whose mean and
// inverse variance live in a 64-entry synchronous ram, loaded by load beats (mode 0). Each data
// beat (mode 1) reads its table entry and is squared, scaled and summed in a three-stage pipe; the
// beat flagged last yields quad_form (Q32.8, saturating) and density = prefactor * exp(-q/2) in
// Q0.32. Load beats and non-last data beats are taken one per cycle; after a last beat the input
// stalls while the pipe drains and the two-multiplier exp stage fills the output register, and
// stays stalled while that register still holds an earlier result under stall; the register
// lets the next vector start while a result waits. Configuration writes
// are always ready and should only be issued while the block is idle.
// depends on dgd_pkg, dgd_accum, dgd_density
`default_nettype none

module diag_gaussian_density (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic                 i_mode,
    input  wire logic [5:0]           i_index,
    input  wire logic signed [15:0]   i_sample,
    input  wire logic signed [15:0]   i_mean_value,
    input  wire logic [15:0]          i_inverse_variance,
    input  wire logic                 i_last,
    // result channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [39:0]               o_quad_form,
    output logic [31:0]               o_density,
    output logic                      o_saturated,
    // configuration write channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [31:0]          i_cfg_data
);

    logic              in_accept;
    logic              cfg_wr;
    logic              res_done;
    logic [31:0]       prefactor;
    dgd_pkg::t_vec_end vec_end;

    logic              r_busy;
    logic              r_use_weight;
    logic              r_sub_mean;
    logic [31:0]       r_w_pref;
    logic [31:0]       r_u_pref;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign o_in_stall  = r_busy;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign prefactor   = r_use_weight ? r_w_pref : r_u_pref;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_use_weight <= 1'b1;
            r_sub_mean   <= 1'b1;
            r_w_pref     <= dgd_pkg::PREF_RESET;
            r_u_pref     <= dgd_pkg::PREF_RESET;
        end else begin
            // one vector end in flight at a time
            if (in_accept && (i_mode == dgd_pkg::MODE_DATA) && i_last) begin
                r_busy <= 1'b1;
            end else if (res_done) begin
                r_busy <= 1'b0;
            end
            if (cfg_wr) begin
                case (dgd_pkg::t_cfg_idx'(i_cfg_index))
                    dgd_pkg::CFG_USE_WEIGHT: r_use_weight <= i_cfg_data[0];
                    dgd_pkg::CFG_SUB_MEAN:   r_sub_mean   <= i_cfg_data[0];
                    dgd_pkg::CFG_W_PREF:     r_w_pref     <= i_cfg_data;
                    dgd_pkg::CFG_U_PREF:     r_u_pref     <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    dgd_accum u_accum (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (in_accept),
        .i_mode             (i_mode),
        .i_index            (i_index),
        .i_sample           (i_sample),
        .i_mean_value       (i_mean_value),
        .i_inverse_variance (i_inverse_variance),
        .i_last             (i_last),
        .i_subtract_mean    (r_sub_mean),
        .o_end              (vec_end)
    );

    dgd_density u_density (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_end       (vec_end),
        .i_prefactor (prefactor),
        .o_done      (res_done),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_quad_form (o_quad_form),
        .o_density   (o_density),
        .o_saturated (o_saturated)
    );

    // a result is only produced for a vector end that was taken in
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_done |-> r_busy)
        else $error("result produced with no vector end outstanding");

endmodule

`default_nettype wire

/* design/dgd_ram.sv */
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`default_nettype none

module dgd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                            i_wr_data,
    input  wire logic                                        i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                            o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* design/dgd_accum.sv */
// mean / inverse-variance table and the per-element square-scale-accumulate pipe
// depends on dgd_pkg and dgd_ram
`default_nettype none

module dgd_accum (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic                 i_mode,
    input  wire logic [5:0]           i_index,
    input  wire logic signed [15:0]   i_sample,
    input  wire logic signed [15:0]   i_mean_value,
    input  wire logic [15:0]          i_inverse_variance,
    input  wire logic                 i_last,
    input  wire logic                 i_subtract_mean,
    output dgd_pkg::t_vec_end         o_end
);

    logic                             data_acc;
    logic                             load_wr;
    dgd_pkg::t_addr                   load_addr;
    logic [dgd_pkg::TBL_W-1:0]        rd_data;

    logic [dgd_pkg::MAX_DIM-1:0]      r_tvld;
    dgd_pkg::t_addr                   r_count;
    logic [dgd_pkg::ACC_W-1:0]        r_acc;
    logic                             r_ovf;

    // stage 1: table word arriving from the ram
    logic                             r_s1_valid;
    logic                             r_s1_last;
    logic                             r_s1_tvld;
    logic signed [15:0]               r_s1_sample;
    // stage 2: squared difference
    logic                             r_s2_valid;
    logic                             r_s2_last;
    logic [31:0]                      r_s2_sq;
    logic [15:0]                      r_s2_iv;
    // stage 3: scaled term
    logic                             r_s3_valid;
    logic                             r_s3_last;
    logic [31:0]                      r_s3_term;

    logic                             r_end_valid;
    logic [dgd_pkg::ACC_W-1:0]        r_end_q;
    logic                             r_end_sat;

    logic signed [15:0]               mean_s;
    logic [15:0]                      iv;
    logic signed [16:0]               diff;
    logic [15:0]                      mag;
    logic [47:0]                      scaled;
    logic [dgd_pkg::ACC_W:0]          sum;
    logic                             sat_now;
    logic [dgd_pkg::ACC_W-1:0]        acc_sat;

    assign data_acc  = i_accept && (i_mode == dgd_pkg::MODE_DATA);
    assign load_addr = dgd_pkg::t_addr'(i_index);
    assign load_wr   = i_accept && (i_mode == dgd_pkg::MODE_LOAD) &&
                       (32'(i_index) < 32'(dgd_pkg::MAX_DIM));

    dgd_ram #(
        .WIDTH (dgd_pkg::TBL_W),
        .DEPTH (dgd_pkg::MAX_DIM)
    ) u_tbl (
        .i_clk     (i_clk),
        .i_wr_en   (load_wr),
        .i_wr_addr (load_addr),
        .i_wr_data ({i_mean_value, i_inverse_variance}),
        .i_rd_en   (data_acc),
        .i_rd_addr (r_count),
        .o_rd_data (rd_data)
    );

    // entries never loaded read as zero mean, unit inverse variance
    always_comb begin
        mean_s = r_s1_tvld ? signed'(rd_data[31:16]) : 16'sd0;
        iv     = r_s1_tvld ? rd_data[15:0] : dgd_pkg::INV_VAR_ONE;
        if (i_subtract_mean) begin
            diff = {r_s1_sample[15], r_s1_sample} - {mean_s[15], mean_s};
        end else begin
            diff = {r_s1_sample[15], r_s1_sample};
        end
        mag = diff[16] ? 16'(17'd0 - diff) : diff[15:0];
    end

    assign scaled  = 48'(r_s2_sq) * 48'(r_s2_iv);
    assign sum     = {1'b0, r_acc} + (dgd_pkg::ACC_W + 1)'(r_s3_term);
    assign sat_now = sum[dgd_pkg::ACC_W];
    assign acc_sat = sat_now ? dgd_pkg::ACC_MAX : sum[dgd_pkg::ACC_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvld      <= '0;
            r_count     <= '0;
            r_acc       <= '0;
            r_ovf       <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_end_valid <= 1'b0;
        end else begin
            if (load_wr) begin
                r_tvld[load_addr] <= 1'b1;
            end
            if (data_acc) begin
                if (i_last || (r_count == dgd_pkg::t_addr'(dgd_pkg::MAX_DIM - 1))) begin
                    r_count <= '0;
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end
            r_s1_valid  <= data_acc;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_end_valid <= r_s3_valid && r_s3_last;
            if (r_s3_valid) begin
                if (r_s3_last) begin
                    r_acc <= '0;
                    r_ovf <= 1'b0;
                end else begin
                    r_acc <= acc_sat;
                    r_ovf <= r_ovf | sat_now;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_sample <= i_sample;
        r_s1_last   <= i_last;
        r_s1_tvld   <= r_tvld[r_count];
        r_s2_sq     <= 32'(mag) * 32'(mag);
        r_s2_iv     <= iv;
        r_s2_last   <= r_s1_last;
        r_s3_term   <= scaled[47:16];
        r_s3_last   <= r_s2_last;
        r_end_q     <= acc_sat;
        r_end_sat   <= r_ovf | sat_now;
    end

    assign o_end = '{valid: r_end_valid, q: r_end_q, sat: r_end_sat};

    // once saturated the sum stays pinned at full scale
    a_sat_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_end_valid && r_end_sat |-> r_end_q == dgd_pkg::ACC_MAX)
        else $error("saturated vector without full-scale quadratic form");

    // a vector end leaves the accumulator clear for the next vector
    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_end_valid |-> (r_acc == '0) && !r_ovf)
        else $error("accumulator not cleared at end of vector");

    // the pipe only carries data elements
    a_pipe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> $past(i_accept) && $past(i_mode) == dgd_pkg::MODE_DATA)
        else $error("pipe stage filled without a data element");

endmodule

`default_nettype wire

/* design/dgd_density.sv */
// exponential table lookup, prefactor scaling and the result output register
// depends on dgd_pkg
`default_nettype none

module dgd_density (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire dgd_pkg::t_vec_end         i_end,
    input  wire logic [31:0]               i_prefactor,
    output logic                           o_done,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [39:0]                    o_quad_form,
    output logic [31:0]                    o_density,
    output logic                           o_saturated
);

    logic [dgd_pkg::ACC_W-1:0]      int_part;
    logic [dgd_pkg::FRAC_BITS-1:0]  frac;
    dgd_pkg::t_exp_prod             idx_full;
    dgd_pkg::t_exp_idx              frac_idx;
    logic [64:0]                    prod1;
    logic [65:0]                    prod2;
    logic [31:0]                    dens;
    logic                           wr_out;

    // lookup stage
    logic                           r_d0_valid;
    logic [dgd_pkg::ACC_W-1:0]      r_d0_q;
    logic                           r_d0_sat;
    logic                           r_d0_zero;
    dgd_pkg::t_rom_word             r_d0_int;
    dgd_pkg::t_rom_word             r_d0_frac;
    // prefactor times exp(-n)
    logic                           r_d1_valid;
    logic [dgd_pkg::ACC_W-1:0]      r_d1_q;
    logic                           r_d1_sat;
    logic                           r_d1_zero;
    logic [32:0]                    r_d1_p;
    dgd_pkg::t_rom_word             r_d1_frac;

    logic                           r_out_valid;
    logic [39:0]                    r_quad_form;
    logic [31:0]                    r_density;
    logic                           r_saturated;

    assign int_part = i_end.q >> dgd_pkg::FRAC_BITS;
    assign frac     = i_end.q[dgd_pkg::FRAC_BITS-1:0];
    assign idx_full = (dgd_pkg::t_exp_prod'(frac) *
                       dgd_pkg::t_exp_prod'(dgd_pkg::EXP_DEPTH)) >> dgd_pkg::FRAC_BITS;
    assign frac_idx = dgd_pkg::t_exp_idx'(idx_full);

    assign prod1 = 65'(i_prefactor) * 65'(r_d0_int);
    assign prod2 = 66'(r_d1_p) * 66'(r_d1_frac);

    always_comb begin
        if (r_d1_zero) begin
            dens = 32'd0;
        end else if (prod2[65:64] != 2'd0) begin
            dens = 32'hFFFF_FFFF;
        end else begin
            dens = prod2[63:32];
        end
    end

    assign wr_out = r_d1_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d0_valid  <= 1'b0;
            r_d1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_d0_valid <= i_end.valid;
            if (r_d0_valid) begin
                r_d1_valid <= 1'b1;
            end else if (wr_out) begin
                r_d1_valid <= 1'b0;
            end
            if (wr_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_end.valid) begin
            r_d0_q    <= i_end.q;
            r_d0_sat  <= i_end.sat;
            r_d0_zero <= int_part >= dgd_pkg::ACC_W'(dgd_pkg::INT_LIMIT);
            r_d0_int  <= dgd_pkg::INT_ROM[int_part[dgd_pkg::INT_IDX_W-1:0]];
            r_d0_frac <= dgd_pkg::FRAC_ROM[frac_idx];
        end
        if (r_d0_valid) begin
            r_d1_q    <= r_d0_q;
            r_d1_sat  <= r_d0_sat;
            r_d1_zero <= r_d0_zero;
            r_d1_p    <= prod1[64:32];
            r_d1_frac <= r_d0_frac;
        end
        if (wr_out) begin
            r_quad_form <= r_d1_q;
            r_density   <= dens;
            r_saturated <= r_d1_sat;
        end
    end

    assign o_done      = wr_out;
    assign o_out_valid = r_out_valid;
    assign o_quad_form = r_quad_form;
    assign o_density   = r_density;
    assign o_saturated = r_saturated;

    // an integer part of 32 or more in q/2 gives zero density
    a_big_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_quad_form[39:14] != 26'd0) |-> o_density == 32'd0)
        else $error("nonzero density for a large quadratic form");

endmodule

`default_nettype wire
